### src/eba_pkg.sv
// ----------------------------------------------------------------------------
// eba_pkg
// Shared widths, item codes and the divider status type of the echo burst
// averager.
// ----------------------------------------------------------------------------
package eba_pkg;

  localparam int KIND_W  = 2;
  localparam int ECHO_W  = 16;
  localparam int SUM_W   = 20;
  localparam int CNT_W   = 4;
  localparam int STEP_W  = $clog2(SUM_W);

  // Longest burst and longest echo accepted into the sum
  localparam int MAX_BURST   = 15;
  localparam int MAX_ECHO_US = 50000;

  localparam logic [KIND_W-1:0] KIND_START  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STOP   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd2;

  typedef struct packed {
    logic done;  // quotient is ready, one-cycle pulse
    logic sat;   // quotient does not fit the result field
  } eba_div_stat_t;

endpackage

### src/eba_sample_if.sv
// ----------------------------------------------------------------------------
// eba_sample_if
// Input channel: one start, stop or echo sample item per handshake.
// ----------------------------------------------------------------------------
interface eba_sample_if import eba_pkg::*;;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [ECHO_W-1:0] echo_us;

  modport source (output valid, output kind, output echo_us, input ready);
  modport sink   (input valid, input kind, input echo_us, output ready);
endinterface

### src/eba_result_if.sv
// ----------------------------------------------------------------------------
// eba_result_if
// Output channel: one averaged echo time item per completed burst.
// ----------------------------------------------------------------------------
interface eba_result_if import eba_pkg::*;;
  logic              valid;
  logic              ready;
  logic [ECHO_W-1:0] echo_time_us;

  modport source (output valid, output echo_time_us, input ready);
  modport sink   (input valid, input echo_time_us, output ready);
endinterface

### src/eba_serdiv.sv
// ----------------------------------------------------------------------------
// eba_serdiv
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
module eba_serdiv import eba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic [SUM_W-1:0]    dividend,
  input  logic [CNT_W-1:0]    divisor,
  output logic [ECHO_W-1:0]   quotient,
  output eba_div_stat_t       stat
);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] step;
  logic [SUM_W-1:0]  quo;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  dvs;

  logic [CNT_W:0]    trial;
  logic              fits;
  logic [CNT_W:0]    diff;

  // Shift the next dividend bit into the partial remainder and try a subtract
  always_comb begin
    trial = {rem, quo[SUM_W-1]};
    fits  = (trial >= {1'b0, dvs});
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        quo  <= dividend;
        rem  <= '0;
        dvs  <= divisor;
      end else if (busy) begin
        rem <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
        quo <= {quo[SUM_W-2:0], fits};
        if (step == STEP_W'(SUM_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
        step <= step + 1'b1;
      end
    end
  end

  assign quotient = quo[ECHO_W-1:0];
  assign stat.done = done;
  assign stat.sat  = |quo[SUM_W-1:ECHO_W];

endmodule

### src/echo_burst_averager.sv
// ----------------------------------------------------------------------------
// echo_burst_averager
// Averages a burst of ultrasonic echo durations into one echo time.
// ----------------------------------------------------------------------------
// Usage:
//   sample_ch takes items of three kinds: start (arm, clear sum and counts),
//   stop (disarm only) and echo sample. Armed samples with a nonzero
//   duration are summed and counted valid; a zero duration counts as a
//   timeout. Once valid plus timeout counts reach burst_size the block
//   disarms and puts one item on result_ch: sum / valid count, or 0 when
//   valid samples do not outnumber timeouts. Other items give no result.
//   cfg_we / cfg_data write burst_size (reset 3); the user must do so only
//   while the block is idle, as the block itself does not enforce it.
// Timing:
//   Start, stop, timeout and ignored items are handled in the idle state.
//   A nonzero sample updates the 20-bit sum one bit per cycle by a serial
//   adder. A sample that completes the burst then passes evaluation, the
//   bit-serial divider (one quotient bit per cycle), the quotient hand-over
//   and the output register load, which waits while that register is full.
// Reset clears the state, disarms the block and drops a pending result.
// A stalled receiver holds the result in the output register; sampling goes
// on, and only the next completed burst waits for the register to empty.
// ----------------------------------------------------------------------------
module echo_burst_averager import eba_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [CNT_W-1:0]    cfg_data,
  eba_sample_if.sink          sample_ch,
  eba_result_if.source        result_ch
);

  typedef enum logic [2:0] {S_IDLE, S_ADD, S_EVAL, S_DIV, S_FIN} state_t;

  state_t            state;
  logic [CNT_W-1:0]  burst_size;
  logic              armed;
  logic [SUM_W-1:0]  echo_sum;
  logic [SUM_W-1:0]  addend;
  logic              carry;
  logic [STEP_W-1:0] step;
  logic [CNT_W-1:0]  valid_count;
  logic [CNT_W-1:0]  timeout_count;
  logic              burst_done;
  logic [ECHO_W-1:0] res;
  logic              out_valid;
  logic [ECHO_W-1:0] out_data;

  logic              accept;
  logic [ECHO_W-1:0] dur;
  logic [CNT_W-1:0]  limit;
  logic [CNT_W-1:0]  valid_count_next;
  logic [CNT_W-1:0]  timeout_count_next;
  logic              sum_bit;
  logic              carry_next;
  logic              div_start;
  logic              out_free;
  logic              out_load;
  logic [ECHO_W-1:0] quotient;
  eba_div_stat_t     div_stat;

  assign sample_ch.ready    = (state == S_IDLE);
  assign accept             = sample_ch.valid && sample_ch.ready;
  assign result_ch.valid    = out_valid;
  assign result_ch.echo_time_us = out_data;
  assign out_free           = !out_valid || result_ch.ready;
  assign out_load           = (state == S_FIN) && out_free;

  always_comb begin
    // Clamp long echoes and oversized bursts
    dur = (32'(sample_ch.echo_us) > MAX_ECHO_US) ? ECHO_W'(MAX_ECHO_US)
                                                 : sample_ch.echo_us;
    limit = (32'(burst_size) > MAX_BURST) ? CNT_W'(MAX_BURST) : burst_size;

    // Saturating counts as they stand after this sample
    valid_count_next   = valid_count;
    timeout_count_next = timeout_count;
    if (dur != '0) begin
      if (valid_count != '1) valid_count_next = valid_count + 1'b1;
    end else begin
      if (timeout_count != '1) timeout_count_next = timeout_count + 1'b1;
    end

    // One bit of the serial sum, LSB first
    sum_bit    = echo_sum[0] ^ addend[0] ^ carry;
    carry_next = (echo_sum[0] & addend[0]) | (carry & (echo_sum[0] ^ addend[0]));

    div_start = (state == S_EVAL) && (valid_count > timeout_count);
  end

  eba_serdiv u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (echo_sum),
    .divisor  (valid_count),
    .quotient (quotient),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      burst_size    <= CNT_W'(3);
      armed         <= 1'b0;
      echo_sum      <= '0;
      valid_count   <= '0;
      timeout_count <= '0;
      burst_done    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        burst_size <= cfg_data;
      end
      // Load a finished average, else drop the result once the receiver
      // takes it
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && result_ch.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (sample_ch.kind)
              KIND_START: begin
                armed         <= 1'b1;
                echo_sum      <= '0;
                valid_count   <= '0;
                timeout_count <= '0;
              end
              KIND_STOP: begin
                armed <= 1'b0;
              end
              KIND_SAMPLE: begin
                if (armed) begin
                  valid_count   <= valid_count_next;
                  timeout_count <= timeout_count_next;
                  burst_done    <= ({1'b0, valid_count_next}
                                    + {1'b0, timeout_count_next})
                                   >= {1'b0, limit};
                  if ({1'b0, valid_count_next} + {1'b0, timeout_count_next}
                      >= {1'b0, limit}) begin
                    armed <= 1'b0;
                  end
                  if (dur != '0) begin
                    // Start the serial add of this duration
                    addend <= SUM_W'(dur);
                    carry  <= 1'b0;
                    step   <= '0;
                    state  <= S_ADD;
                  end else if ({1'b0, valid_count_next} + {1'b0, timeout_count_next}
                               >= {1'b0, limit}) begin
                    state <= S_EVAL;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end

        S_ADD: begin
          addend <= addend >> 1;
          carry  <= carry_next;
          step   <= step + 1'b1;
          if (step == STEP_W'(SUM_W - 1)) begin
            // Carry out of the top bit means the sum saturates
            echo_sum <= carry_next ? '1 : {sum_bit, echo_sum[SUM_W-1:1]};
            state    <= burst_done ? S_EVAL : S_IDLE;
          end else begin
            echo_sum <= {sum_bit, echo_sum[SUM_W-1:1]};
          end
        end

        S_EVAL: begin
          // Too few valid samples: report zero without dividing
          if (valid_count > timeout_count) begin
            state <= S_DIV;
          end else begin
            res   <= '0;
            state <= S_FIN;
          end
        end

        S_DIV: begin
          if (div_stat.done) begin
            res   <= div_stat.sat ? '1 : quotient;
            state <= S_FIN;
          end
        end

        S_FIN: begin
          // Hold until the output register is free
          if (out_load) begin
            out_data  <= res;
            state     <= S_IDLE;
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### src/eba_checker.sv
// ----------------------------------------------------------------------------
// eba_checker
// Port-level checks of the echo burst averager, bound to the top level.
// ----------------------------------------------------------------------------
module eba_checker import eba_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ECHO_W-1:0] out_data
);

  // A stalled result item stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result item dropped while stalled");

  // A stalled result item keeps its value
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result item changed while stalled");

  // An average never exceeds the longest accepted echo
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> 32'(out_data) <= MAX_ECHO_US)
    else $error("averaged echo time out of range");

  // A new result only follows a busy cycle of the sample channel
  a_out_after_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !$past(out_valid) |-> !$past(in_ready))
    else $error("result appeared without burst processing");

endmodule

bind echo_burst_averager eba_checker u_eba_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (sample_ch.ready),
  .out_valid (result_ch.valid),
  .out_ready (result_ch.ready),
  .out_data  (result_ch.echo_time_us)
);
